[sv/pileup_base_call_parser_top_defines.svh]
// Assertion macros shared by the checker of the pileup base-call parser.
// Holds only macro definitions; no dependencies.
`ifndef PILEUP_BASE_CALL_PARSER_TOP_DEFINES_SVH
`define PILEUP_BASE_CALL_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Next-cycle implication, disabled while reset is asserted.
`define PBCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

[sv/pbcp_pkg.sv]
// Shared types and constants of the pileup base-call parser.
// No dependencies; used by every module of the block.
`default_nettype none

package pbcp_pkg;

  localparam int MAX_STRATA    = 1024;
  localparam int STRATUM_W     = 10;
  localparam logic [STRATUM_W-1:0] STRATUM_MAX = STRATUM_W'(MAX_STRATA - 1);

  localparam int INDEL_LIMIT   = 4095;
  localparam int INDEL_ACC_W   = 12;
  localparam int INDEL_W       = 13;
  localparam int INDEL_EXT_W   = INDEL_ACC_W + 4;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = 2;
  localparam int QUEUE_CNT_W   = 3;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [1:0] STRAND_NONE = 2'd0;
  localparam logic [1:0] STRAND_FWD  = 2'd1;
  localparam logic [1:0] STRAND_REV  = 2'd2;

  localparam logic [1:0] MARK_NONE  = 2'd0;
  localparam logic [1:0] MARK_START = 2'd1;
  localparam logic [1:0] MARK_END   = 2'd2;
  localparam logic [1:0] MARK_GAP   = 2'd3;

  // One result record.
  typedef struct packed {
    logic                      last;
    logic                      unknown_char;
    logic signed [INDEL_W-1:0] indel_length;
    logic [7:0]                start_map_quality;
    logic [1:0]                read_mark;
    logic [1:0]                strand;
    logic [7:0]                base;
    logic [STRATUM_W-1:0]      stratum_index;
  } rec_t;

  // What one character produces: one or two records, first in rec0.
  typedef struct packed {
    rec_t rec0;
    rec_t rec1;
    logic two;
  } entry_t;

endpackage

`default_nettype wire

[sv/pbcp_front.sv]
// Front end of the pileup base-call parser: accepts characters, runs the
// column parser and packs the records of each character into a queue entry.
// Depends on pbcp_pkg.
`default_nettype none

module pbcp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       ch,
  input  wire logic [7:0]       ref_base,
  input  wire logic             coverage_zero,
  input  wire logic             line_end,
  input  wire logic             push_room,
  output logic                  push,
  output pbcp_pkg::entry_t      push_entry
);

  typedef enum logic [5:0] {
    PH_BASE       = 6'b000001,
    PH_START_Q    = 6'b000010,
    PH_START_BASE = 6'b000100,
    PH_AFTER_BASE = 6'b001000,
    PH_DIGITS     = 6'b010000,
    PH_SKIP       = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] base;
    logic [1:0] strand;
    logic [1:0] mark;
    logic       unk;
  } dec_t;

  phase_t                              ph_r, ph_nxt;
  logic                                pend_valid_r, pend_valid_nxt;
  dec_t                                pend_r, pend_nxt;
  logic [7:0]                          mapq_r, mapq_nxt;
  logic [pbcp_pkg::INDEL_ACC_W-1:0]    acc_r, acc_nxt;
  logic                                neg_r, neg_nxt;
  logic [pbcp_pkg::INDEL_ACC_W-1:0]    skip_r, skip_nxt;
  logic [pbcp_pkg::STRATUM_W-1:0]      cnt_r, cnt_nxt;

  logic                                fire;
  logic                                begin_s;
  logic                                emit_a;
  logic                                emit_b;
  pbcp_pkg::rec_t                      rec_a;
  pbcp_pkg::rec_t                      rec_b;
  logic [pbcp_pkg::INDEL_EXT_W-1:0]    acc_mac;
  logic [pbcp_pkg::INDEL_ACC_W-1:0]    acc_m1;
  logic [pbcp_pkg::INDEL_ACC_W-1:0]    skip_dec;

  // Resolves a base character; marks other than a gap are kept.
  function automatic dec_t decode_ch(input logic [7:0] c, input logic [7:0] rb,
                                     input dec_t cur);
    dec_t d;
    d     = cur;
    d.unk = 1'b0;
    case (c) inside
      pbcp_pkg::CH_DOT: begin
        d.strand = pbcp_pkg::STRAND_FWD;
        d.base   = rb;
      end
      pbcp_pkg::CH_COMMA: begin
        d.strand = pbcp_pkg::STRAND_REV;
        d.base   = rb;
      end
      "A", "C", "G", "T", "N": begin
        d.strand = pbcp_pkg::STRAND_FWD;
        d.base   = c;
      end
      "a", "c", "g", "t", "n": begin
        d.strand = pbcp_pkg::STRAND_REV;
        d.base   = c - pbcp_pkg::CASE_OFFSET;
      end
      pbcp_pkg::CH_STAR: begin
        d.base = pbcp_pkg::CH_STAR;
        d.mark = pbcp_pkg::MARK_GAP;
      end
      default: begin
        d.unk  = 1'b1;
        d.base = 8'h00;
      end
    endcase
    return d;
  endfunction

  function automatic pbcp_pkg::rec_t make_rec(
      input logic [pbcp_pkg::STRATUM_W-1:0]   idx,
      input dec_t                             p,
      input logic [7:0]                       mq,
      input logic [pbcp_pkg::INDEL_ACC_W-1:0] acc,
      input logic                             neg,
      input logic                             last);
    pbcp_pkg::rec_t r;
    logic [pbcp_pkg::INDEL_W-1:0] mag;
    mag                 = {1'b0, acc};
    r.stratum_index     = idx;
    r.base              = p.base;
    r.strand            = p.strand;
    r.read_mark         = p.mark;
    r.start_map_quality = mq;
    r.indel_length      = neg ? ($signed(pbcp_pkg::INDEL_W'(0)) - $signed(mag))
                              : $signed(mag);
    r.unknown_char      = p.unk;
    r.last              = last;
    return r;
  endfunction

  assign in_ready = push_room;
  assign fire     = in_valid & push_room;

  assign acc_mac  = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0}
                  + pbcp_pkg::INDEL_EXT_W'(ch - pbcp_pkg::CH_ZERO);
  assign acc_m1   = acc_r - 1'b1;
  assign skip_dec = (skip_r != '0) ? skip_r - 1'b1 : skip_r;

  always_comb begin
    ph_nxt         = ph_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    mapq_nxt       = mapq_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    skip_nxt       = skip_r;
    cnt_nxt        = cnt_r;
    begin_s        = 1'b0;
    emit_a         = 1'b0;

    if (!coverage_zero) begin
      case (ph_r)
        PH_START_Q: begin
          mapq_nxt = ch;
          ph_nxt   = PH_START_BASE;
        end
        PH_START_BASE: begin
          pend_nxt = decode_ch(ch, ref_base, pend_r);
          ph_nxt   = PH_AFTER_BASE;
        end
        PH_AFTER_BASE: begin
          if (ch == pbcp_pkg::CH_DOLLAR) begin
            pend_nxt.mark = pbcp_pkg::MARK_END;
            ph_nxt        = PH_BASE;
          end else if (ch == pbcp_pkg::CH_PLUS || ch == pbcp_pkg::CH_MINUS) begin
            neg_nxt = (ch == pbcp_pkg::CH_MINUS);
            acc_nxt = '0;
            ph_nxt  = PH_DIGITS;
          end else begin
            begin_s = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (ch inside {[pbcp_pkg::CH_ZERO:pbcp_pkg::CH_NINE]}) begin
            acc_nxt = (acc_mac > pbcp_pkg::INDEL_EXT_W'(pbcp_pkg::INDEL_LIMIT))
                    ? pbcp_pkg::INDEL_ACC_W'(pbcp_pkg::INDEL_LIMIT)
                    : acc_mac[pbcp_pkg::INDEL_ACC_W-1:0];
          end else if (acc_r == '0) begin
            begin_s = 1'b1;
          end else begin
            skip_nxt = acc_m1;
            ph_nxt   = (acc_m1 != '0) ? PH_SKIP : PH_BASE;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            ph_nxt = PH_BASE;
          end
        end
        default: begin
          begin_s = 1'b1;
        end
      endcase
    end

    // A new stratum pushes out the pending one and takes its place.
    if (begin_s) begin
      emit_a = pend_valid_r;
      if (pend_valid_r && cnt_r < pbcp_pkg::STRATUM_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      pend_valid_nxt = 1'b1;
      mapq_nxt       = 8'h00;
      acc_nxt        = '0;
      neg_nxt        = 1'b0;
      skip_nxt       = '0;
      if (ch == pbcp_pkg::CH_CARET) begin
        pend_nxt = '{base: 8'h00, strand: pbcp_pkg::STRAND_NONE,
                     mark: pbcp_pkg::MARK_START, unk: 1'b1};
        ph_nxt   = PH_START_Q;
      end else begin
        pend_nxt = decode_ch(ch, ref_base,
                             '{base: 8'h00, strand: pbcp_pkg::STRAND_NONE,
                               mark: pbcp_pkg::MARK_NONE, unk: 1'b1});
        ph_nxt   = PH_AFTER_BASE;
      end
    end

    rec_a  = make_rec(cnt_r, pend_r, mapq_r, acc_r, neg_r, 1'b0);
    rec_b  = make_rec(cnt_nxt, pend_nxt, mapq_nxt, acc_nxt, neg_nxt, 1'b1);
    emit_b = line_end & pend_valid_nxt;

    // Line end flushes what is pending and returns the line state to reset.
    if (line_end) begin
      ph_nxt         = PH_BASE;
      pend_valid_nxt = 1'b0;
      pend_nxt       = '0;
      mapq_nxt       = 8'h00;
      acc_nxt        = '0;
      neg_nxt        = 1'b0;
      skip_nxt       = '0;
      cnt_nxt        = '0;
    end
  end

  assign push            = fire & (emit_a | emit_b);
  assign push_entry.rec0 = emit_a ? rec_a : rec_b;
  assign push_entry.rec1 = rec_b;
  assign push_entry.two  = emit_a & emit_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r         <= PH_BASE;
      pend_valid_r <= 1'b0;
      pend_r       <= '0;
      mapq_r       <= 8'h00;
      acc_r        <= '0;
      neg_r        <= 1'b0;
      skip_r       <= '0;
      cnt_r        <= '0;
    end else if (fire) begin
      ph_r         <= ph_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_r       <= pend_nxt;
      mapq_r       <= mapq_nxt;
      acc_r        <= acc_nxt;
      neg_r        <= neg_nxt;
      skip_r       <= skip_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/pbcp_queue.sv]
// Short FIFO of record entries between the parser front end and the
// output stage. Depends on pbcp_pkg.
`default_nettype none

module pbcp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pbcp_pkg::entry_t  push_entry,
  output logic                   push_room,
  input  wire logic              pop,
  output logic                   head_valid,
  output pbcp_pkg::entry_t       head_entry
);

  pbcp_pkg::entry_t                   slots [pbcp_pkg::QUEUE_DEPTH];
  logic [pbcp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [pbcp_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [pbcp_pkg::QUEUE_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                               do_pop;

  function automatic logic [pbcp_pkg::QUEUE_CNT_W-1:0] QUEUE_CNT_W_ONE(input logic b);
    return {{(pbcp_pkg::QUEUE_CNT_W-1){1'b0}}, b};
  endfunction

  assign push_room  = (cnt_r != pbcp_pkg::QUEUE_CNT_W'(pbcp_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = slots[rd_ptr_r];
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QUEUE_CNT_W_ONE(push) - QUEUE_CNT_W_ONE(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/pbcp_back.sv]
// Output stage of the pileup base-call parser: splits queue entries into
// single records and holds each in the output register. Depends on pbcp_pkg.
`default_nettype none

module pbcp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire pbcp_pkg::entry_t  head_entry,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pbcp_pkg::rec_t         out_rec
);

  logic            out_valid_r, out_valid_nxt;
  pbcp_pkg::rec_t  out_rec_r, out_rec_nxt;
  logic            half_r, half_nxt;
  logic            load;

  assign load = head_valid & (~out_valid_r | out_ready);
  assign pop  = load & ~(head_entry.two & ~half_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rec_nxt   = out_rec_r;
    half_nxt      = half_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_rec_nxt   = half_r ? head_entry.rec1 : head_entry.rec0;
      half_nxt      = head_entry.two & ~half_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r <= out_rec_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

endmodule

`default_nettype wire

[sv/pileup_base_call_parser_top.sv]
// Pileup base-call column parser. It takes one character of a pileup line's
// base-call column per cycle, with the line's reference base, a zero-coverage
// flag and a line-end mark, and returns one record per read of the pile:
// the resolved upper-case base ('.' and ',' become the reference base), the
// strand, the read mark (start with its mapping-quality character, end, or
// deletion gap), the signed indel length and the read's position in the pile.
// A read is held until the next read begins or the line ends, so a record
// leaves zero or more characters after the read's first character, and the
// line-end character can release two records (the last one with tlast set).
// Rate: one character is accepted every cycle while the entry queue between
// the parser and the output stage has room. The output register sends one
// record per cycle while out_tready is high, so a character that releases two
// records holds the output longer than one that releases one; the four-entry
// queue absorbs that and output stalls until it is full.
// Depends on pbcp_pkg, pbcp_front, pbcp_queue and pbcp_back.
`default_nettype none

module pileup_base_call_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // ch [7:0], ref_base [15:8]
  input  wire logic        in_tuser,   // coverage_zero
  input  wire logic        in_tlast,   // line end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // stratum_index [9:0], base [17:10],
                                       // strand [19:18], read_mark [21:20],
                                       // start_map_quality [29:22],
                                       // indel_length [42:30], zeros above
  output logic             out_tuser,  // unknown_char
  output logic             out_tlast   // final read of the line
);

  logic              push;
  logic              push_room;
  pbcp_pkg::entry_t  push_entry;
  logic              pop;
  logic              head_valid;
  pbcp_pkg::entry_t  head_entry;
  pbcp_pkg::rec_t    out_rec;

  // The front end parses characters and packs their records.
  pbcp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .ch            (in_tdata[7:0]),
    .ref_base      (in_tdata[15:8]),
    .coverage_zero (in_tuser),
    .line_end      (in_tlast),
    .push_room     (push_room),
    .push          (push),
    .push_entry    (push_entry)
  );

  // The queue lets the parser run ahead while the output is stalled.
  pbcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_room  (push_room),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // The output stage sends each entry's records one per cycle unless stalled.
  pbcp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_rec    (out_rec)
  );

  assign out_tdata = {5'b00000,
                      out_rec.indel_length,
                      out_rec.start_map_quality,
                      out_rec.read_mark,
                      out_rec.strand,
                      out_rec.base,
                      out_rec.stratum_index};
  assign out_tuser = out_rec.unknown_char;
  assign out_tlast = out_rec.last;

endmodule

`default_nettype wire

[sv/pbcp_checker.sv]
// Port-level checker of the pileup base-call parser and its bind.
// Depends on pbcp_pkg and pileup_base_call_parser_top_defines.svh.
`default_nettype none
`include "pileup_base_call_parser_top_defines.svh"

module pbcp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [15:0] in_tdata,
  input wire logic        in_tuser,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // A record that is not taken stays offered.
  `PBCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // A stalled record keeps its contents.
  `PBCP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // A deletion gap always carries the gap character as its base.
  `PBCP_ASSERT_IMPL(a_gap_base, clk, rst_n, out_tvalid && out_tdata[21:20] == pbcp_pkg::MARK_GAP, out_tdata[17:10] == pbcp_pkg::CH_STAR)

  // An unrecognized base has no base value and no strand.
  `PBCP_ASSERT_IMPL(a_unknown_empty, clk, rst_n, out_tvalid && out_tuser, out_tdata[17:10] == 8'h00 && out_tdata[19:18] == pbcp_pkg::STRAND_NONE)

endmodule

bind pileup_base_call_parser_top pbcp_checker u_pbcp_checker (.*);

`default_nettype wire
